// ===== hdl/i2cmbe_pkg.sv =====
// types, codes and phase numbers shared by the i2c master byte engine
// no dependencies; compile first
package i2cmbe_pkg;

   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef logic [3:0] phase_type;

   // start sequence
   localparam phase_type ST_SCL_RELEASE = 4'd0;
   localparam phase_type ST_SDA_LOW     = 4'd1;
   localparam phase_type ST_LAST        = ST_SDA_LOW;
   // stop sequence
   localparam phase_type SP_SDA_LOW     = 4'd0;
   localparam phase_type SP_SCL_RELEASE = 4'd1;
   localparam phase_type SP_SDA_RELEASE = 4'd2;
   localparam phase_type SP_LAST        = SP_SDA_RELEASE;
   // write sequence
   localparam phase_type WR_BIT_SCL_LOW  = 4'd0;
   localparam phase_type WR_BIT_SDA      = 4'd1;
   localparam phase_type WR_BIT_SCL_HIGH = 4'd2;
   localparam phase_type WR_ACK_SCL_LOW  = 4'd3;
   localparam phase_type WR_ACK_RELEASE  = 4'd4;
   localparam phase_type WR_ACK_SCL_HIGH = 4'd5;
   localparam phase_type WR_END_SCL_LOW  = 4'd6;
   localparam phase_type WR_LAST         = WR_END_SCL_LOW;
   // read sequence
   localparam phase_type RD_BIT_SCL_LOW  = 4'd0;
   localparam phase_type RD_BIT_SCL_HIGH = 4'd1;
   localparam phase_type RD_ACK_SCL_LOW  = 4'd2;
   localparam phase_type RD_ACK_DRIVE    = 4'd3;
   localparam phase_type RD_ACK_SCL_HIGH = 4'd4;
   localparam phase_type RD_END_SCL_LOW  = 4'd5;
   localparam phase_type RD_LAST         = RD_END_SCL_LOW;

   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;

   typedef struct packed {
      logic [2:0] kind;
      logic       sda_in;
      logic [7:0] write_byte;
      logic       send_ack;
   } req_type;

   typedef struct packed {
      logic       scl_low;
      logic       sda_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_seen;
   } rsp_type;

   typedef struct packed {
      op_type     operation;
      phase_type  phase;
      logic [3:0] bit_count;
      logic [15:0] tick_count;
      logic [7:0] shift_reg;
      logic       scl_drive;
      logic       sda_drive;
      logic       ack_flag;
      logic       ack_choice;
      logic [7:0] last_read;
   } state_type;

endpackage

// ===== hdl/i2cmbe_step.sv =====
// next-state and result logic for one tick of the byte engine
// depends on i2cmbe_pkg
module i2cmbe_step (
   input  i2cmbe_pkg::state_type cur,
   input  i2cmbe_pkg::req_type   req,
   input  logic [15:0]           phase_ticks,
   output i2cmbe_pkg::state_type nxt,
   output i2cmbe_pkg::rsp_type   rsp
);
   import i2cmbe_pkg::*;

   // drive change on entering a phase
   function automatic state_type enter_phase(input state_type s);
      state_type r;
      r = s;
      case (s.operation)
         OP_START: begin
            if (s.phase == ST_SCL_RELEASE) r.scl_drive = 1'b0;
            else r.sda_drive = 1'b1;
         end
         OP_STOP: begin
            if (s.phase == SP_SDA_LOW) r.sda_drive = 1'b1;
            else if (s.phase == SP_SCL_RELEASE) r.scl_drive = 1'b0;
            else r.sda_drive = 1'b0;
         end
         OP_WRITE: begin
            case (s.phase)
               WR_BIT_SCL_LOW:  r.scl_drive = 1'b1;
               WR_BIT_SDA:      r.sda_drive = ~s.shift_reg[7];
               WR_BIT_SCL_HIGH: r.scl_drive = 1'b0;
               WR_ACK_SCL_LOW:  r.scl_drive = 1'b1;
               WR_ACK_RELEASE:  r.sda_drive = 1'b0;
               WR_ACK_SCL_HIGH: r.scl_drive = 1'b0;
               default:         r.scl_drive = 1'b1;
            endcase
         end
         OP_READ: begin
            case (s.phase)
               RD_BIT_SCL_LOW: begin
                  r.scl_drive = 1'b1;
                  r.sda_drive = 1'b0;
               end
               RD_BIT_SCL_HIGH: r.scl_drive = 1'b0;
               RD_ACK_SCL_LOW:  r.scl_drive = 1'b1;
               RD_ACK_DRIVE:    r.sda_drive = s.ack_choice;
               RD_ACK_SCL_HIGH: r.scl_drive = 1'b0;
               default:         r.scl_drive = 1'b1;
            endcase
         end
         default: r = s;
      endcase
      return r;
   endfunction

   logic [15:0] limit;
   logic [3:0]  bit_inc;
   phase_type   last;
   logic        finished;
   logic        done;
   state_type   s;

   assign limit   = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
   assign bit_inc = cur.bit_count + 4'd1;

   always_comb begin
      case (cur.operation)
         OP_START: last = ST_LAST;
         OP_STOP:  last = SP_LAST;
         OP_WRITE: last = WR_LAST;
         OP_READ:  last = RD_LAST;
         default:  last = '0;
      endcase
   end

   always_comb begin
      s        = cur;
      finished = 1'b0;
      done     = 1'b0;
      if (cur.operation == OP_IDLE) begin
         if (req.kind >= OP_START && req.kind <= OP_READ) begin
            s.operation  = op_type'(req.kind);
            s.phase      = '0;
            s.bit_count  = '0;
            s.tick_count = 16'd1;
            if (req.kind == OP_WRITE) s.shift_reg = req.write_byte;
            if (req.kind == OP_READ) begin
               s.shift_reg  = '0;
               s.ack_choice = req.send_ack;
            end
            s = enter_phase(s);
         end
      end else if (cur.tick_count >= limit) begin
         if (cur.operation == OP_WRITE && cur.phase == WR_BIT_SCL_HIGH) begin
            s.shift_reg = {cur.shift_reg[6:0], 1'b0};
            s.bit_count = bit_inc;
            s.phase     = (bit_inc >= BITS_PER_BYTE) ? WR_ACK_SCL_LOW : WR_BIT_SCL_LOW;
         end else if (cur.operation == OP_READ && cur.phase == RD_BIT_SCL_HIGH) begin
            s.shift_reg = {cur.shift_reg[6:0], req.sda_in};
            s.bit_count = bit_inc;
            s.phase     = (bit_inc >= BITS_PER_BYTE) ? RD_ACK_SCL_LOW : RD_BIT_SCL_LOW;
         end else begin
            if (cur.operation == OP_WRITE && cur.phase == WR_ACK_SCL_HIGH)
               s.ack_flag = ~req.sda_in;
            if (cur.phase >= last || cur.operation == OP_IDLE) begin
               finished = 1'b1;
               if (cur.operation == OP_READ) s.last_read = cur.shift_reg;
            end else begin
               s.phase = cur.phase + 4'd1;
            end
         end
         if (finished) begin
            s.operation  = OP_IDLE;
            s.phase      = '0;
            s.tick_count = '0;
            done         = 1'b1;
         end else begin
            s.tick_count = 16'd1;
            s = enter_phase(s);
         end
      end else begin
         s.tick_count = cur.tick_count + 16'd1;
      end
   end

   assign nxt          = s;
   assign rsp.scl_low   = s.scl_drive;
   assign rsp.sda_low   = s.sda_drive;
   assign rsp.busy_res  = (s.operation != OP_IDLE);
   assign rsp.done_res  = done;
   assign rsp.read_byte = s.last_read;
   assign rsp.ack_seen  = s.ack_flag;

endmodule

// ===== hdl/i2c_master_byte_engine.sv =====
// i2c master byte engine: each accepted word's result is registered as it is
// taken; throughput one word per cycle unless the receiver stalls, set by the
// single pass of step logic between the state and result registers
// reset (synchronous, active high) returns the sequencer to idle with both
// lines released, clears the flags and sets phase_ticks to 50
// depends on i2cmbe_pkg and i2cmbe_step
module i2c_master_byte_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cmbe_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cmbe_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata
);
   import i2cmbe_pkg::*;

   // sequencer state, advanced once per accepted word (one bus tick)
   state_type   state_ff;
   state_type   state_in;
   // ticks per bus phase
   logic [15:0] phase_ticks_ff;
   // result register, parts the request side from the response side
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;
   logic        accept;

   // take a new word whenever the result slot is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   i2cmbe_step u_step (
      .cur         (state_ff),
      .req         (req_data),
      .phase_ticks (phase_ticks_ff),
      .nxt         (state_in),
      .rsp         (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         // all-zero state is idle with both lines released
         state_ff           <= '0;
         phase_ticks_ff     <= PHASE_TICKS_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_we) phase_ticks_ff <= csr_wdata;
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer only moves on an accepted word
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("sequencer state moved without a word");

   // every accepted word leaves a result waiting
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   // busy flag of a fresh result matches the sequencer state
   a_busy_match: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_data_ff.busy_res == (state_ff.operation != OP_IDLE)))
      else $error("busy flag disagrees with sequencer state");

   // done only on the tick the sequencer falls back to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !(rsp_data_ff.done_res && state_ff.operation != OP_IDLE))
      else $error("done pulse while still busy");

   // phase length changes only through the register port
   a_ticks_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> $stable(phase_ticks_ff))
      else $error("phase_ticks changed without a write");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the i2c master byte engine: a directed table, then
// random tick words checked against a cycle-true sequencer predictor
// depends on i2cmbe_pkg and the i2c_master_byte_engine rtl
`timescale 1ns / 1ps

module testbench;
   import i2cmbe_pkg::*;

   // tick-only and unused command codes on the kind field
   localparam logic [2:0] KIND_TICK       = 3'd0;
   localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
   localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
   localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;

   localparam int unsigned CYCLE_LIMIT = 400000;

   // result words that can be read straight off the sequence
   localparam rsp_type RSP_QUIET = '0;
   localparam rsp_type RSP_START_ENTERED = '{scl_low: 1'b0, sda_low: 1'b0, busy_res: 1'b1,
                                             done_res: 1'b0, read_byte: 8'h00,
                                             ack_seen: 1'b0};

   // one row of the directed script
   typedef struct packed {
      logic        csr;      // row writes phase_ticks instead of sending a word
      logic [15:0] ticks;
      logic [2:0]  kind;
      logic        sda;
      logic [7:0]  wbyte;
      logic        ack;
      logic [7:0]  pad;      // tick-only words sent after this one
      logic        pad_sda;
      logic        pinned;   // result typed in below rather than predicted
      rsp_type     want;
   } script_row;

   typedef struct packed {
      logic    pinned;
      rsp_type value;
   } typed_result;

   // columns: csr, ticks, kind, sda, byte, ack, pad, pad_sda, pinned, want
   localparam script_row SCRIPT [23] = '{
      // straight after reset: ticks and unused kinds leave everything quiet
      '{1'b0, 16'd0, KIND_TICK,       1'b0, 8'h00, 1'b0, 8'd0, 1'b0, 1'b1, RSP_QUIET},
      '{1'b0, 16'd0, KIND_TICK,       1'b1, 8'hFF, 1'b1, 8'd0, 1'b0, 1'b1, RSP_QUIET},
      '{1'b0, 16'd0, KIND_UNUSED_LO,  1'b0, 8'h00, 1'b0, 8'd0, 1'b0, 1'b1, RSP_QUIET},
      '{1'b0, 16'd0, KIND_UNUSED_MID, 1'b1, 8'h55, 1'b0, 8'd0, 1'b0, 1'b1, RSP_QUIET},
      '{1'b0, 16'd0, KIND_UNUSED_HI,  1'b0, 8'hAA, 1'b1, 8'd0, 1'b0, 1'b1, RSP_QUIET},
      // start at the reset rate, then drop phase_ticks to zero mid-sequence
      '{1'b0, 16'd0, OP_START,        1'b1, 8'h00, 1'b0, 8'd3, 1'b1, 1'b1, RSP_START_ENTERED},
      '{1'b1, 16'd0, KIND_TICK,       1'b0, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, RSP_QUIET},
      // write while busy, then stop on the done tick: both ignored
      '{1'b0, 16'd0, OP_WRITE,        1'b0, 8'hFF, 1'b0, 8'd0, 1'b0, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, OP_STOP,         1'b1, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, RSP_QUIET},
      // byte extremes: writes with ack and nack from the slave, reads with ack and nack sent
      '{1'b0, 16'd0, OP_WRITE,        1'b1, 8'hFF, 1'b0, 8'd30, 1'b0, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, OP_WRITE,        1'b0, 8'h00, 1'b1, 8'd30, 1'b1, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, OP_READ,         1'b0, 8'h00, 1'b1, 8'd22, 1'b1, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, OP_READ,         1'b1, 8'hFF, 1'b0, 8'd22, 1'b0, 1'b0, RSP_QUIET},
      '{1'b1, 16'd1, KIND_TICK,       1'b0, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, RSP_QUIET},
      // stop, a read while busy, a write on the done tick, then a start
      '{1'b0, 16'd0, OP_STOP,         1'b0, 8'h00, 1'b0, 8'd1, 1'b1, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, OP_READ,         1'b0, 8'h00, 1'b1, 8'd0, 1'b0, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, OP_WRITE,        1'b1, 8'h3C, 1'b0, 8'd0, 1'b0, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, OP_START,        1'b0, 8'h00, 1'b0, 8'd4, 1'b0, 1'b0, RSP_QUIET},
      // longest phase: the write sits in its first phase, then speeds up
      '{1'b1, 16'hFFFF, KIND_TICK,    1'b0, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, OP_WRITE,        1'b0, 8'hA5, 1'b0, 8'd20, 1'b0, 1'b0, RSP_QUIET},
      '{1'b1, 16'd2, KIND_TICK,       1'b0, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, KIND_TICK,       1'b0, 8'h00, 1'b0, 8'd70, 1'b0, 1'b0, RSP_QUIET},
      '{1'b0, 16'd0, OP_READ,         1'b1, 8'h00, 1'b1, 8'd50, 1'b1, 1'b0, RSP_QUIET}
   };

   // phase_ticks for each random stretch, one of them drawn at run time
   localparam logic [15:0] STRETCH_TICKS [8] = '{16'd1, 16'd2, 16'd0, 16'd3,
                                                 16'd1, 16'd4, 16'd2, 16'd1};

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [15:0] csr_wdata = '0;

   // predictor state and its copy of the register
   state_type   seq_state;
   logic [15:0] phase_ticks_cfg;

   rsp_type     bus_state_q [$];   // predicted line states still to arrive
   typed_result typed_q [$];       // one per word sent, popped on acceptance
   rsp_type     predicted;
   typed_result typed_now;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   bit          send_idle_on  = 1'b1;
   bit          rsp_stalls_on = 1'b1;

   always #1 clock = ~clock;

   i2c_master_byte_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------- predictor

   // line drive taken up on entry to the current phase
   function automatic void drive_phase();
      case (seq_state.operation)
         OP_START: begin
            if (seq_state.phase == ST_SCL_RELEASE) seq_state.scl_drive = 1'b0;
            else seq_state.sda_drive = 1'b1;
         end
         OP_STOP: begin
            if (seq_state.phase == SP_SDA_LOW) seq_state.sda_drive = 1'b1;
            else if (seq_state.phase == SP_SCL_RELEASE) seq_state.scl_drive = 1'b0;
            else seq_state.sda_drive = 1'b0;
         end
         OP_WRITE: begin
            case (seq_state.phase)
               WR_BIT_SCL_LOW:  seq_state.scl_drive = 1'b1;
               WR_BIT_SDA:      seq_state.sda_drive = ~seq_state.shift_reg[7];
               WR_BIT_SCL_HIGH: seq_state.scl_drive = 1'b0;
               WR_ACK_SCL_LOW:  seq_state.scl_drive = 1'b1;
               WR_ACK_RELEASE:  seq_state.sda_drive = 1'b0;
               WR_ACK_SCL_HIGH: seq_state.scl_drive = 1'b0;
               default:         seq_state.scl_drive = 1'b1;
            endcase
         end
         OP_READ: begin
            case (seq_state.phase)
               // sda let go at the start of every data bit
               RD_BIT_SCL_LOW: begin
                  seq_state.scl_drive = 1'b1;
                  seq_state.sda_drive = 1'b0;
               end
               RD_BIT_SCL_HIGH: seq_state.scl_drive = 1'b0;
               RD_ACK_SCL_LOW:  seq_state.scl_drive = 1'b1;
               RD_ACK_DRIVE:    seq_state.sda_drive = seq_state.ack_choice;
               RD_ACK_SCL_HIGH: seq_state.scl_drive = 1'b0;
               default:         seq_state.scl_drive = 1'b1;
            endcase
         end
         default: ;
      endcase
   endfunction

   // closes the current phase on this tick's sda; 1 when the command is over
   function automatic logic finish_phase(input logic sda);
      phase_type last_phase;
      case (seq_state.operation)
         OP_START: last_phase = ST_LAST;
         OP_STOP:  last_phase = SP_LAST;
         OP_WRITE: last_phase = WR_LAST;
         OP_READ:  last_phase = RD_LAST;
         default:  return 1'b1;
      endcase
      if (seq_state.operation == OP_WRITE && seq_state.phase == WR_BIT_SCL_HIGH) begin
         seq_state.shift_reg = {seq_state.shift_reg[6:0], 1'b0};
         seq_state.bit_count = seq_state.bit_count + 4'd1;
         seq_state.phase = (seq_state.bit_count >= BITS_PER_BYTE) ? WR_ACK_SCL_LOW
                                                                  : WR_BIT_SCL_LOW;
         return 1'b0;
      end
      if (seq_state.operation == OP_READ && seq_state.phase == RD_BIT_SCL_HIGH) begin
         seq_state.shift_reg = {seq_state.shift_reg[6:0], sda};
         seq_state.bit_count = seq_state.bit_count + 4'd1;
         seq_state.phase = (seq_state.bit_count >= BITS_PER_BYTE) ? RD_ACK_SCL_LOW
                                                                  : RD_BIT_SCL_LOW;
         return 1'b0;
      end
      if (seq_state.operation == OP_WRITE && seq_state.phase == WR_ACK_SCL_HIGH)
         seq_state.ack_flag = ~sda;
      if (seq_state.phase >= last_phase) begin
         if (seq_state.operation == OP_READ) seq_state.last_read = seq_state.shift_reg;
         return 1'b1;
      end
      seq_state.phase = seq_state.phase + 4'd1;
      return 1'b0;
   endfunction

   // one tick of the sequencer, returns the line state after it
   function automatic rsp_type advance_sequencer(input req_type w);
      rsp_type     r;
      logic [15:0] limit;
      logic        finished;
      limit = (phase_ticks_cfg == 16'd0) ? 16'd1 : phase_ticks_cfg;
      finished = 1'b0;
      if (seq_state.operation == OP_IDLE) begin
         // commands are only taken up while idle
         if (w.kind >= OP_START && w.kind <= OP_READ) begin
            seq_state.operation = op_type'(w.kind);
            seq_state.phase = '0;
            seq_state.bit_count = '0;
            seq_state.tick_count = 16'd1;
            if (w.kind == OP_WRITE) seq_state.shift_reg = w.write_byte;
            if (w.kind == OP_READ) begin
               seq_state.shift_reg = '0;
               seq_state.ack_choice = w.send_ack;
            end
            drive_phase();
         end
      end else if (seq_state.tick_count >= limit) begin
         if (finish_phase(w.sda_in)) begin
            seq_state.operation = OP_IDLE;
            seq_state.phase = '0;
            seq_state.tick_count = '0;
            finished = 1'b1;
         end else begin
            seq_state.tick_count = 16'd1;
            drive_phase();
         end
      end else begin
         seq_state.tick_count = seq_state.tick_count + 16'd1;
      end
      r.scl_low   = seq_state.scl_drive;
      r.sda_low   = seq_state.sda_drive;
      r.busy_res  = (seq_state.operation != OP_IDLE);
      r.done_res  = finished;
      r.read_byte = seq_state.last_read;
      r.ack_seen  = seq_state.ack_flag;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_result(input rsp_type got, input rsp_type want);
      if (got.scl_low !== want.scl_low) begin
         $error("scl_low: expected %0b, got %0b", want.scl_low, got.scl_low);
         error_count++;
      end
      if (got.sda_low !== want.sda_low) begin
         $error("sda_low: expected %0b, got %0b", want.sda_low, got.sda_low);
         error_count++;
      end
      if (got.busy_res !== want.busy_res) begin
         $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
         error_count++;
      end
      if (got.done_res !== want.done_res) begin
         $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
         error_count++;
      end
      if (got.read_byte !== want.read_byte) begin
         $error("read_byte: expected %02h, got %02h", want.read_byte, got.read_byte);
         error_count++;
      end
      if (got.ack_seen !== want.ack_seen) begin
         $error("ack_seen: expected %0b, got %0b", want.ack_seen, got.ack_seen);
         error_count++;
      end
   endtask

   // everything sampled at the edge sees pre-edge values; results are checked
   // before the word taken at the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (bus_state_q.size() == 0) begin
               $error("result word with no expectation waiting");
               error_count++;
            end else begin
               check_result(rsp_data, bus_state_q.pop_front());
            end
         end
         if (csr_we) phase_ticks_cfg = csr_wdata;
         if (req_valid && req_ready) begin
            predicted = advance_sequencer(req_data);
            typed_now = typed_q.pop_front();
            // typed-in rows are checked against the table, the rest against the predictor
            bus_state_q.push_back(typed_now.pinned ? typed_now.value : predicted);
         end
      end
   end

   // ---------------------------------------------------------------- idling

   // mostly short gaps, now and then a long one
   function automatic int unsigned gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // receiver back-pressure, switched off for some stretches
   always @(posedge clock) begin
      if (reset || !rsp_stalls_on) begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
         stall_left <= gap_length() - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // offers one word and returns at the edge that takes it; valid stays up
   task automatic send_word(input req_type w, input logic pinned, input rsp_type want);
      int unsigned gap;
      gap = 0;
      if (send_idle_on && $urandom_range(0, 99) < 35) gap = gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_q.push_back('{pinned: pinned, value: want});
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold the sender until every word sent has come back
   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (typed_q.size() + bus_state_q.size() != 0) @(posedge clock);
   endtask

   // register written only with nothing in flight
   task automatic write_phase_ticks(input logic [15:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      script_row   row;
      req_type     w;
      int unsigned roll;

      seq_state = '0;
      seq_state.operation = OP_IDLE;
      phase_ticks_cfg = PHASE_TICKS_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed script
      for (int i = 0; i < $size(SCRIPT); i++) begin
         row = SCRIPT[i];
         if (row.csr) begin
            write_phase_ticks(row.ticks);
         end else begin
            w = '{kind: row.kind, sda_in: row.sda, write_byte: row.wbyte, send_ack: row.ack};
            send_word(w, row.pinned, row.want);
            for (int k = 0; k < row.pad; k++) begin
               w = '{kind: KIND_TICK, sda_in: row.pad_sda, write_byte: 8'($urandom),
                     send_ack: 1'($urandom)};
               send_word(w, 1'b0, RSP_QUIET);
            end
         end
      end

      // random stretches, each at its own phase_ticks and idling mix
      for (int p = 0; p < $size(STRETCH_TICKS); p++) begin
         write_phase_ticks((p == 5) ? 16'($urandom_range(1, 4)) : STRETCH_TICKS[p]);
         send_idle_on  = (p % 4 == 1) || (p % 4 == 3);
         rsp_stalls_on = (p % 4 == 2) || (p % 4 == 3);
         for (int n = 0; n < 80; n++) begin
            // sender holds off mid-stretch until the pipe is empty
            if (p == 3 && n == 40) wait_drained();
            roll = $urandom_range(0, 99);
            // mostly ticks with random sda so commands progress, some commands,
            // a few unused kinds
            if (roll < 84) w.kind = KIND_TICK;
            else if (roll < 97) w.kind = 3'($urandom_range(OP_START, OP_READ));
            else w.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            w.sda_in     = 1'($urandom);
            w.write_byte = 8'($urandom);
            w.send_ack   = 1'($urandom);
            send_word(w, 1'b0, RSP_QUIET);
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (bus_state_q.size() != 0) begin
         $error("%0d expected result words never arrived", bus_state_q.size());
         error_count++;
      end
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/i2cmbe_pkg.sv
hdl/i2cmbe_step.sv
hdl/i2c_master_byte_engine.sv
tb/testbench.sv
